### design/prm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prm_pkg
// Shared widths and constants for the period-to-rate meter.
// ----------------------------------------------------------------------------
package prm_pkg;

   localparam int NUM_WIDTH  = 36;
   localparam int DIV_WIDTH  = NUM_WIDTH + 1;
   localparam int STEP_WIDTH = $clog2(DIV_WIDTH);
   localparam int OUT_WIDTH  = 24;

   localparam logic [OUT_WIDTH-1:0] OUT_MAX   = {OUT_WIDTH{1'b1}};
   localparam logic [NUM_WIDTH-1:0] NUM_RESET = 36'd36000000000;

endpackage : prm_pkg
`default_nettype wire

### design/prm_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prm_req_if
// Pin sample channel: one sampled level per transfer.
// ----------------------------------------------------------------------------
interface prm_req_if;

   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink   (input valid, input pin_level, output ready);

endinterface : prm_req_if
`default_nettype wire

### design/prm_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prm_rsp_if
// Measurement result channel: rate, period and overflow flag.
// ----------------------------------------------------------------------------
interface prm_rsp_if;
   import prm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OUT_WIDTH-1:0] rate_centi;
   logic [OUT_WIDTH-1:0] period_ticks;
   logic                 overflowed;

   modport source (output valid, output rate_centi, output period_ticks,
                   output overflowed, input ready);
   modport sink   (input valid, input rate_centi, input period_ticks,
                   input overflowed, output ready);

endinterface : prm_rsp_if
`default_nettype wire

### design/prm_csr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prm_csr_if
// Register write channel carrying the rate numerator.
// ----------------------------------------------------------------------------
interface prm_csr_if;
   import prm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [NUM_WIDTH-1:0] rate_numerator;

   modport source (output valid, output rate_numerator, input ready);
   modport sink   (input valid, input rate_numerator, output ready);

endinterface : prm_csr_if
`default_nettype wire

### design/prm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prm_front
// Edge tracker and period counter. Takes one pin sample per transfer and
// pushes {saturated, count} into the queue on the closing rising edge.
// ----------------------------------------------------------------------------
module prm_front #(
   parameter int COUNT_WIDTH = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   prm_req_if.sink                   req_chan,
   input  wire logic                 q_full,
   output logic                      push,
   output logic [COUNT_WIDTH:0]      push_data
);
   import prm_pkg::*;

   typedef enum logic [1:0] {
      WAIT_LOW,
      WAIT_HIGH,
      COUNT_HIGH,
      COUNT_LOW
   } phase_type;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in, cnt_tick;
   logic                   sat_ff, sat_in, sat_tick;
   logic                   accept;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   always_comb begin
      if (cnt_ff == CNT_MAX) begin
         cnt_tick = cnt_ff;
         sat_tick = 1'b1;
      end else begin
         cnt_tick = cnt_ff + COUNT_WIDTH'(1);
         sat_tick = sat_ff;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      sat_in   = sat_ff;
      push     = 1'b0;
      if (accept) begin
         case (phase_ff)
            WAIT_LOW: begin
               if (!req_chan.pin_level) phase_in = WAIT_HIGH;
            end
            WAIT_HIGH: begin
               if (req_chan.pin_level) begin
                  cnt_in   = '0;
                  sat_in   = 1'b0;
                  phase_in = COUNT_HIGH;
               end
            end
            COUNT_HIGH: begin
               cnt_in = cnt_tick;
               sat_in = sat_tick;
               if (!req_chan.pin_level) phase_in = COUNT_LOW;
            end
            COUNT_LOW: begin
               cnt_in = cnt_tick;
               sat_in = sat_tick;
               if (req_chan.pin_level) begin
                  push     = 1'b1;
                  phase_in = WAIT_LOW;
               end
            end
            default: phase_in = WAIT_LOW;
         endcase
      end
   end

   assign push_data = {sat_tick, cnt_tick};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= WAIT_LOW;
         cnt_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         sat_ff   <= sat_in;
      end
   end

endmodule : prm_front
`default_nettype wire

### design/prm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prm_queue
// Small FIFO between the counter and the divider, head shown ahead.
// ----------------------------------------------------------------------------
module prm_queue #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head_data,
   output logic                  full,
   output logic                  empty
);
   import prm_pkg::*;

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_WIDTH-1:0] count_ff;
   logic                 do_push, do_pop;

   assign full      = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
         if (do_pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + CNT_WIDTH'(1);
            2'b01:   count_ff <= count_ff - CNT_WIDTH'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule : prm_queue
`default_nettype wire

### design/prm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prm_back
// Numerator register, bit-serial restoring divider and result register.
// Rate is (numerator + count/2) / count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prm_back #(
   parameter int COUNT_WIDTH = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   prm_csr_if.sink                   csr_chan,
   prm_rsp_if.source                 rsp_chan,
   input  wire logic                 q_empty,
   input  wire logic [COUNT_WIDTH:0] q_data,
   output logic                      pop
);
   import prm_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      RUN,
      HOLD
   } state_type;

   localparam int PER_WIDTH = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;

   state_type               state_ff;
   logic [NUM_WIDTH-1:0]    num_ff;
   logic [DIV_WIDTH-1:0]    dvd_ff, dvd_in;
   logic [COUNT_WIDTH-1:0]  rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0]  div_ff, div_in;
   logic                    sat_ff, sat_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic                    rsp_valid_ff;
   logic [OUT_WIDTH-1:0]    rate_ff, per_ff;
   logic                    ovf_ff;

   logic [COUNT_WIDTH:0]    shifted, diff;
   logic                    ge;
   logic                    last_step;
   logic                    out_free;
   logic                    load_out;
   logic                    rate_sat, per_sat;
   logic [PER_WIDTH-1:0]    per_ext;
   logic [OUT_WIDTH-1:0]    rate_res, per_res;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) num_ff <= NUM_RESET;
      else if (csr_chan.valid) num_ff <= csr_chan.rate_numerator;
   end

   assign pop       = (state_ff == IDLE) && !q_empty;
   assign shifted   = {rem_ff, dvd_ff[DIV_WIDTH-1]};
   assign ge        = shifted >= {1'b0, div_ff};
   assign diff      = shifted - {1'b0, div_ff};
   assign last_step = (step_ff == STEP_WIDTH'(DIV_WIDTH - 1));
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign load_out  = (state_ff == HOLD) && out_free;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      sat_in  = sat_ff;
      step_in = step_ff;
      if (pop) begin
         dvd_in  = DIV_WIDTH'(num_ff) + DIV_WIDTH'(q_data[COUNT_WIDTH-1:1]);
         rem_in  = '0;
         div_in  = q_data[COUNT_WIDTH-1:0];
         sat_in  = q_data[COUNT_WIDTH];
         step_in = '0;
      end else if (state_ff == RUN) begin
         dvd_in  = {dvd_ff[DIV_WIDTH-2:0], ge};
         rem_in  = ge ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
         step_in = step_ff + STEP_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      sat_ff  <= sat_in;
      step_ff <= step_in;
   end

   // quotient sits in dvd_ff once the last step is done
   assign rate_sat = dvd_ff > DIV_WIDTH'(OUT_MAX);
   assign rate_res = rate_sat ? OUT_MAX : dvd_ff[OUT_WIDTH-1:0];
   assign per_ext  = PER_WIDTH'(div_ff);
   assign per_sat  = per_ext > PER_WIDTH'(OUT_MAX);
   assign per_res  = per_sat ? OUT_MAX : per_ext[OUT_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= load_out || (rsp_valid_ff && !rsp_chan.ready);
         case (state_ff)
            IDLE: begin
               if (pop) state_ff <= RUN;
            end
            RUN: begin
               if (last_step) state_ff <= HOLD;
            end
            HOLD: begin
               if (out_free) begin
                  rate_ff  <= rate_res;
                  per_ff   <= per_res;
                  ovf_ff   <= sat_ff || rate_sat || per_sat;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.rate_centi   = rate_ff;
   assign rsp_chan.period_ticks = per_ff;
   assign rsp_chan.overflowed   = ovf_ff;

endmodule : prm_back
`default_nettype wire

### design/period_to_rate_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// period_to_rate_meter
// Reciprocal period meter: counts ticks between two rising pin edges and
// reports the count and numerator / count in hundredths per minute.
//
//   channel    dir  payload                                   fires on
//   req_chan   in   pin_level                                 every tick
//   rsp_chan   out  rate_centi, period_ticks, overflowed      closing edge
//   csr_chan   in   rate_numerator                            register write
//
// Pin samples: one per cycle while the result queue has room.
// Each report occupies the serial divider for load, a step per quotient bit and
// hand-off; QUEUE_DEPTH reports can wait for it, then req_chan.ready drops.
// rsp_chan stalls hold the result; the divider runs on, then waits in HOLD.
// Synchronous reset restores the numerator and waits for a low level.
// ----------------------------------------------------------------------------
module period_to_rate_meter #(
   parameter int COUNT_WIDTH = 24,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   prm_req_if.sink   req_chan,
   prm_rsp_if.source rsp_chan,
   prm_csr_if.sink   csr_chan
);
   import prm_pkg::*;

   logic                 push, pop, q_full, q_empty;
   logic [COUNT_WIDTH:0] push_data, head_data;

   prm_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   prm_queue #(
      .WIDTH (COUNT_WIDTH + 1),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   prm_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .rsp_chan (rsp_chan),
      .q_empty  (q_empty),
      .q_data   (head_data),
      .pop      (pop)
   );

endmodule : period_to_rate_meter
`default_nettype wire

### design/prm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prm_checker
// Port-level checks for the period-to-rate meter, bound to the top level.
// ----------------------------------------------------------------------------
module prm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [prm_pkg::OUT_WIDTH-1:0] rsp_rate_centi,
   input wire logic [prm_pkg::OUT_WIDTH-1:0] rsp_period_ticks,
   input wire logic                          rsp_overflowed,
   input wire logic                          csr_ready
);
   import prm_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rate_centi)
         && $stable(rsp_period_ticks) && $stable(rsp_overflowed))
      else $error("stalled result changed");

   a_period_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overflowed |-> rsp_period_ticks >= OUT_WIDTH'(2))
      else $error("period below two ticks without overflow");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port not ready");

endmodule : prm_checker

bind period_to_rate_meter prm_checker u_prm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_rate_centi   (rsp_chan.rate_centi),
   .rsp_period_ticks (rsp_chan.period_ticks),
   .rsp_overflowed   (rsp_chan.overflowed),
   .csr_ready        (csr_chan.ready)
);
`default_nettype wire
